// ===== src/sba_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the slot bitmap allocator.
// No dependencies; every other file except sba_ram imports this package.
package sba_pkg;

   // Slot index width and the hard ceiling on addressable slots
   localparam int SLOT_W      = 10;
   localparam int SLOT_LIMIT  = 1024;

   // Reciprocal divide: row = (idx * RECIP) >> RECIP_SHIFT, exact for idx < 1024
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 14;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request function codes as they arrive on the port
   typedef enum logic [1:0] {
      FUNC_FIND    = 2'd0,
      FUNC_TAKE    = 2'd1,
      FUNC_RELEASE = 2'd2
   } func_type;

   // Classified command handed to the back end
   typedef enum logic [2:0] {
      OP_FIND    = 3'd0,  // scan for a free slot
      OP_TAKE    = 3'd1,  // set the slot bit
      OP_RELEASE = 3'd2,  // clear the slot bit
      OP_MISS    = 3'd3,  // find with start beyond capacity
      OP_ECHO    = 3'd4   // no state change, echo the index
   } op_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_LOOK  = 2'd2,
      ST_REPLY = 2'd3
   } back_state_type;

endpackage

// ===== src/slot_bitmap_allocator_unit.sv =====
`timescale 1ns / 1ps
// Slot bitmap allocator top level. Out-of-range and unused requests skip the bitmap RAM;
// take/release read and write back one row, and a find reads rows until a hit or the last row.
// The back end handles one command at a time, while the queue lets the front end accept more;
// during a find the bitmap RAM reads one row per cycle, up to 32 rows by default.
// Reset: synchronous; afterwards a clearing pass writes every used row, with req_ready
// low until it finishes. Depends on sba_pkg and all sba_ modules.
module slot_bitmap_allocator_unit import sba_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int NUM_WORDS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [SLOT_W-1:0] req_slot_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_found_slot,
   output logic              rsp_none_free
);

   localparam int TOTAL     = WORD_BITS * NUM_WORDS;
   localparam int CAP       = (TOTAL < SLOT_LIMIT) ? TOTAL : SLOT_LIMIT;
   localparam int USED_ROWS = (CAP + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W     = (USED_ROWS > 1) ? $clog2(USED_ROWS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int OP_W      = $bits(op_type);
   localparam int CMD_W     = OP_W + 2 * SLOT_W + ROW_W + BIT_W;

   logic              init_busy;
   logic              f_valid, f_ready;
   op_type            f_op;
   logic [SLOT_W-1:0] f_idx, f_base;
   logic [ROW_W-1:0]  f_row;
   logic [BIT_W-1:0]  f_bit;
   logic [CMD_W-1:0]  f_data, q_data;
   logic              q_valid, q_ready;
   logic [OP_W-1:0]   q_op_raw;
   op_type            q_op;
   logic [SLOT_W-1:0] q_idx, q_base;
   logic [ROW_W-1:0]  q_row;
   logic [BIT_W-1:0]  q_bit;

   // request intake and classification
   sba_front #(
      .WORD_BITS (WORD_BITS),
      .NUM_WORDS (NUM_WORDS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .init_busy      (init_busy),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_slot_index (req_slot_index),
      .cmd_valid      (f_valid),
      .cmd_ready      (f_ready),
      .cmd_op         (f_op),
      .cmd_idx        (f_idx),
      .cmd_base       (f_base),
      .cmd_row        (f_row),
      .cmd_bit        (f_bit)
   );

   assign f_data = {f_op, f_idx, f_base, f_row, f_bit};

   // command queue
   sba_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign {q_op_raw, q_idx, q_base, q_row, q_bit} = q_data;
   assign q_op = op_type'(q_op_raw);

   // bitmap engine and response register
   sba_back #(
      .WORD_BITS (WORD_BITS),
      .NUM_WORDS (NUM_WORDS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .init_busy      (init_busy),
      .cmd_valid      (q_valid),
      .cmd_ready      (q_ready),
      .cmd_op         (q_op),
      .cmd_idx        (q_idx),
      .cmd_base       (q_base),
      .cmd_row        (q_row),
      .cmd_bit        (q_bit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found_slot (rsp_found_slot),
      .rsp_none_free  (rsp_none_free)
   );

endmodule

// ===== src/sba_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sba_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, splits the index into row and bit, classifies the request.
// Depends on sba_pkg.
module sba_front import sba_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int NUM_WORDS = 32,
   localparam int TOTAL     = WORD_BITS * NUM_WORDS,
   localparam int CAP       = (TOTAL < SLOT_LIMIT) ? TOTAL : SLOT_LIMIT,
   localparam int USED_ROWS = (CAP + WORD_BITS - 1) / WORD_BITS,
   localparam int ROW_W     = (USED_ROWS > 1) ? $clog2(USED_ROWS) : 1,
   localparam int BIT_W     = $clog2(WORD_BITS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              init_busy,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [SLOT_W-1:0] req_slot_index,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output op_type            cmd_op,
   output logic [SLOT_W-1:0] cmd_idx,
   output logic [SLOT_W-1:0] cmd_base,
   output logic [ROW_W-1:0]  cmd_row,
   output logic [BIT_W-1:0]  cmd_bit
);

   localparam int IDX_ROW_W = $clog2((SLOT_LIMIT - 1) / WORD_BITS + 1);
   localparam int RECIP     = (2 ** RECIP_SHIFT + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W    = SLOT_W + RECIP_W;
   localparam logic [SLOT_W:0] CAP_V = (SLOT_W + 1)'(CAP);

   logic                 a_valid_ff, a_valid_in;
   logic [1:0]           a_func_ff;
   logic [SLOT_W-1:0]    a_idx_ff;
   logic [IDX_ROW_W-1:0] a_row_ff;

   logic                 accept;
   logic [PROD_W-1:0]    prod;
   logic [SLOT_W-1:0]    row_ext;
   logic [SLOT_W-1:0]    bit_diff;
   logic                 in_cap;

   // hold off new requests while the bitmap is being cleared
   assign req_ready = !init_busy && (!a_valid_ff || cmd_ready);
   assign accept    = req_valid && req_ready;

   // row by reciprocal multiply
   assign prod = PROD_W'(req_slot_index) * PROD_W'(RECIP);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (cmd_ready) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_func_ff <= req_func;
         a_idx_ff  <= req_slot_index;
         a_row_ff  <= prod[RECIP_SHIFT +: IDX_ROW_W];
      end
   end

   // row base and bit position
   assign row_ext  = SLOT_W'(a_row_ff);
   assign cmd_base = row_ext * SLOT_W'(WORD_BITS);
   assign bit_diff = a_idx_ff - cmd_base;
   assign cmd_bit  = bit_diff[BIT_W-1:0];
   assign cmd_row  = a_row_ff[ROW_W-1:0];
   assign cmd_idx  = a_idx_ff;
   assign in_cap   = {1'b0, a_idx_ff} < CAP_V;
   assign cmd_valid = a_valid_ff;

   // classify
   always_comb begin
      case (func_type'(a_func_ff))
         FUNC_FIND:    cmd_op = in_cap ? OP_FIND : OP_MISS;
         FUNC_TAKE:    cmd_op = in_cap ? OP_TAKE : OP_ECHO;
         FUNC_RELEASE: cmd_op = in_cap ? OP_RELEASE : OP_ECHO;
         default:      cmd_op = OP_ECHO;
      endcase
   end

endmodule

// ===== src/sba_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO of classified commands between front and back end.
// Depends on sba_pkg only for the import convention.
module sba_queue import sba_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = data_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/sba_back.sv =====
`timescale 1ns / 1ps
// Back end: clears the bitmap after reset, runs scans and bit updates, holds the response.
// Depends on sba_pkg and sba_ram.
module sba_back import sba_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int NUM_WORDS = 32,
   localparam int TOTAL     = WORD_BITS * NUM_WORDS,
   localparam int CAP       = (TOTAL < SLOT_LIMIT) ? TOTAL : SLOT_LIMIT,
   localparam int USED_ROWS = (CAP + WORD_BITS - 1) / WORD_BITS,
   localparam int ROW_W     = (USED_ROWS > 1) ? $clog2(USED_ROWS) : 1,
   localparam int BIT_W     = $clog2(WORD_BITS)
) (
   input  logic              clock,
   input  logic              reset,
   output logic              init_busy,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  op_type            cmd_op,
   input  logic [SLOT_W-1:0] cmd_idx,
   input  logic [SLOT_W-1:0] cmd_base,
   input  logic [ROW_W-1:0]  cmd_row,
   input  logic [BIT_W-1:0]  cmd_bit,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_found_slot,
   output logic              rsp_none_free
);

   localparam int LAST_ROW  = USED_ROWS - 1;
   localparam int LAST_BITS = CAP - LAST_ROW * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
   localparam logic [ROW_W-1:0]  LAST_ROW_IDX = ROW_W'(LAST_ROW);
   localparam logic [SLOT_W-1:0] ROW_STEP     = SLOT_W'(WORD_BITS);
   localparam logic [SLOT_W:0]   CAP_V        = (SLOT_W + 1)'(CAP);

   back_state_type    state_ff, state_in;
   logic [ROW_W-1:0]  clr_ff, clr_in;
   op_type            op_ff, op_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0] base_ff, base_in;
   logic              first_ff, first_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              res_none_ff, res_none_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_none_ff, rsp_none_in;

   logic                 ram_wr_en, ram_rd_en;
   logic [ROW_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;

   logic [WORD_BITS-1:0] bit_hot, low_mask, tail_mask, free_bits;
   logic [BIT_W-1:0]     hit_pos;
   logic                 any_free;
   logic [SLOT_W-1:0]    found_pos;
   logic                 out_free;

   sba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (USED_ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // masks for the row under inspection
   assign bit_hot   = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_ff;
   assign low_mask  = first_ff ? (bit_hot - {{(WORD_BITS - 1){1'b0}}, 1'b1}) : '0;
   assign tail_mask = (row_ff == LAST_ROW_IDX) ? LAST_MASK : '1;
   assign free_bits = ~(ram_rd_data | low_mask) & tail_mask;
   assign any_free  = |free_bits;

   // lowest free bit
   always_comb begin
      hit_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            hit_pos = BIT_W'(b);
         end
      end
   end

   assign found_pos = base_ff + SLOT_W'(hit_pos);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign init_busy = state_ff == ST_CLEAR;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      bit_in      = bit_ff;
      row_in      = row_ff;
      base_in     = base_ff;
      first_in    = first_ff;
      res_slot_in = res_slot_ff;
      res_none_in = res_none_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_none_in  = rsp_none_ff;
      cmd_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = row_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cmd_row;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ROW_W'(1);
            if (clr_ff == LAST_ROW_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               op_in    = cmd_op;
               idx_in   = cmd_idx;
               bit_in   = cmd_bit;
               row_in   = cmd_row;
               base_in  = cmd_base;
               first_in = 1'b1;
               case (cmd_op)
                  OP_FIND, OP_TAKE, OP_RELEASE: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_LOOK;
                  end
                  OP_MISS: begin
                     res_slot_in = '0;
                     res_none_in = 1'b1;
                     state_in    = ST_REPLY;
                  end
                  default: begin
                     res_slot_in = cmd_idx;
                     res_none_in = 1'b0;
                     state_in    = ST_REPLY;
                  end
               endcase
            end
         end

         ST_LOOK: begin
            case (op_ff)
               OP_TAKE: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data | bit_hot;
                  res_slot_in = idx_ff;
                  res_none_in = 1'b0;
                  state_in    = ST_REPLY;
               end
               OP_RELEASE: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data & ~bit_hot;
                  res_slot_in = idx_ff;
                  res_none_in = 1'b0;
                  state_in    = ST_REPLY;
               end
               OP_FIND: begin
                  if (any_free) begin
                     res_slot_in = found_pos;
                     res_none_in = 1'b0;
                     state_in    = ST_REPLY;
                  end else if (row_ff == LAST_ROW_IDX) begin
                     res_slot_in = '0;
                     res_none_in = 1'b1;
                     state_in    = ST_REPLY;
                  end else begin
                     // next row, one per cycle
                     row_in      = row_ff + ROW_W'(1);
                     base_in     = base_ff + ROW_STEP;
                     first_in    = 1'b0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = row_ff + ROW_W'(1);
                  end
               end
               default: begin
                  res_slot_in = idx_ff;
                  res_none_in = 1'b0;
                  state_in    = ST_REPLY;
               end
            endcase
         end

         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_none_in  = res_none_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      bit_ff      <= bit_in;
      row_ff      <= row_in;
      base_ff     <= base_in;
      first_ff    <= first_in;
      res_slot_ff <= res_slot_in;
      res_none_ff <= res_none_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found_slot = rsp_slot_ff;
   assign rsp_none_free  = rsp_none_ff;

   // the bitmap is written only by the clearing pass or a take/release
   a_write_scope: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR ||
                     (state_ff == ST_LOOK && (op_ff == OP_TAKE || op_ff == OP_RELEASE))))
      else $error("bitmap write outside clear or update");

   // scan never walks past the last used row
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |-> row_ff <= LAST_ROW_IDX)
      else $error("scan row beyond last row");

   // a hit lies at or above the start and inside capacity
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && op_ff == OP_FIND && any_free) |->
         (found_pos >= idx_ff && {1'b0, found_pos} < CAP_V))
      else $error("found slot out of range");

   // a miss always reports slot zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_none_ff) |-> rsp_slot_ff == '0)
      else $error("miss with nonzero slot");

   // clearing ends only after the last row was written
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff) == ST_CLEAR) |-> $past(clr_ff) == LAST_ROW_IDX)
      else $error("clearing pass cut short");

endmodule
